/* rtl/core/assert_macros.svh */
// Assertion helpers used by the bound checker module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define AK_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

// Check an implication on every rising clock edge outside reset.
`define AK_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication failed");

`endif

/* rtl/core/aes128ke_pkg.sv */
`default_nettype none
package aes128ke_pkg;

    localparam int NUM_ROUNDS = 10;
    localparam int KEY_W      = 128;
    localparam int HALF_W     = 64;
    localparam int IDX_W      = 4;
    localparam int IN_DATA_W  = 128;
    localparam int OUT_DATA_W = 136;

    typedef logic [KEY_W-1:0] t_key;
    typedef logic [IDX_W-1:0] t_round;

    localparam t_round LAST_ROUND = t_round'(NUM_ROUNDS);

    localparam logic [7:0] SBOX [0:255] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    // Round constant for rounds 1..10; top byte of the first word.
    function automatic logic [7:0] rcon(input t_round round);
        logic [7:0] rc;
        case (round)
            4'd1:    rc = 8'h01;
            4'd2:    rc = 8'h02;
            4'd3:    rc = 8'h04;
            4'd4:    rc = 8'h08;
            4'd5:    rc = 8'h10;
            4'd6:    rc = 8'h20;
            4'd7:    rc = 8'h40;
            4'd8:    rc = 8'h80;
            4'd9:    rc = 8'h1b;
            4'd10:   rc = 8'h36;
            default: rc = 8'h00;
        endcase
        return rc;
    endfunction

endpackage
`default_nettype wire

/* rtl/core/aes128ke_round.sv */
`default_nettype none
module aes128ke_round (
    input  wire aes128ke_pkg::t_key   i_key,
    input  wire aes128ke_pkg::t_round i_round,
    output aes128ke_pkg::t_key        o_key
);
    import aes128ke_pkg::*;

    logic [31:0] w0, w1, w2, w3;
    logic [31:0] rot, sub, t;
    logic [31:0] n0, n1, n2, n3;

    always_comb begin
        {w0, w1, w2, w3} = i_key;
        rot = {w3[23:0], w3[31:24]};
        sub = {SBOX[rot[31:24]], SBOX[rot[23:16]], SBOX[rot[15:8]], SBOX[rot[7:0]]};
        t   = sub ^ {rcon(i_round), 24'h000000};
        n0  = w0 ^ t;
        n1  = w1 ^ n0;
        n2  = w2 ^ n1;
        n3  = w3 ^ n2;
    end

    assign o_key = {n0, n1, n2, n3};

endmodule
`default_nettype wire

/* rtl/core/aes128_key_expansion.sv */
// Round key 0 is registered on the output in the cycle after the key beat is accepted.
// Throughput: 11 output beats per key, one per cycle while the output is not stalled; a
// new key is taken in the cycle after round 10 is produced if the output can advance, as
// keys are expanded one at a time by the single round-step unit making one round key per cycle.
// Reset (i_rst_n low, synchronous): drops any run in progress and the output beat.
`default_nettype none
module aes128_key_expansion (
    input  wire                                   i_clk,
    input  wire                                   i_rst_n,
    input  wire                                   s_axis_tvalid,
    output logic                                  s_axis_tready,
    // [63:0] key_high, [127:64] key_low
    input  wire  [aes128ke_pkg::IN_DATA_W-1:0]    s_axis_tdata,
    output logic                                  m_axis_tvalid,
    input  wire                                   m_axis_tready,
    // [3:0] round_index, [67:4] round_key_high, [131:68] round_key_low, [135:132] zero
    output logic [aes128ke_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
    output logic                                  m_axis_tlast
);
    import aes128ke_pkg::*;

    // Expansion engine: r_key holds the round key last issued, r_round the next
    // round to compute, r_busy marks a run still in progress.
    logic   r_busy,  n_busy;
    t_round r_round, n_round;
    t_key   r_key,   n_key;

    // Output register, the skid point between engine and downstream.
    logic   r_out_valid, n_out_valid;
    t_round r_out_index, n_out_index;
    t_key   r_out_key,   n_out_key;
    logic   r_out_last,  n_out_last;

    logic   adv;
    logic   in_beat;
    t_key   in_key;
    t_key   step_key;

    // Advance whenever the output register is empty or being drained.
    assign adv           = !r_out_valid || m_axis_tready;
    assign s_axis_tready = adv && !r_busy;
    assign in_beat       = s_axis_tvalid && s_axis_tready;

    // Word 0 sits in the top bits of the internal key.
    assign in_key = {s_axis_tdata[HALF_W-1:0], s_axis_tdata[IN_DATA_W-1:HALF_W]};

    aes128ke_round u_round (
        .i_key   (r_key),
        .i_round (r_round),
        .o_key   (step_key)
    );

    always_comb begin
        n_busy      = r_busy;
        n_round     = r_round;
        n_key       = r_key;
        n_out_valid = r_out_valid;
        n_out_index = r_out_index;
        n_out_key   = r_out_key;
        n_out_last  = r_out_last;
        if (adv) begin
            if (r_busy) begin
                // Issue the next round key and keep it as the seed of the one after.
                n_out_valid = 1'b1;
                n_out_index = r_round;
                n_out_key   = step_key;
                n_out_last  = (r_round == LAST_ROUND);
                n_key       = step_key;
                n_round     = r_round + t_round'(1);
                n_busy      = (r_round != LAST_ROUND);
            end else if (in_beat) begin
                // Round 0 is the key itself.
                n_out_valid = 1'b1;
                n_out_index = '0;
                n_out_key   = in_key;
                n_out_last  = 1'b0;
                n_key       = in_key;
                n_round     = t_round'(1);
                n_busy      = 1'b1;
            end else begin
                n_out_valid = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_round     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_busy      <= n_busy;
            r_round     <= n_round;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key       <= n_key;
        r_out_index <= n_out_index;
        r_out_key   <= n_out_key;
        r_out_last  <= n_out_last;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tlast  = r_out_last;
    assign m_axis_tdata  = {4'b0000, r_out_key[HALF_W-1:0], r_out_key[KEY_W-1:HALF_W],
                            r_out_index};

endmodule
`default_nettype wire

/* rtl/core/aes128ke_checker.sv */
`default_nettype none
`include "assert_macros.svh"
module aes128ke_checker (
    input wire         i_clk,
    input wire         i_rst_n,
    input wire         s_axis_tvalid,
    input wire         s_axis_tready,
    input wire [127:0] s_axis_tdata,
    input wire         m_axis_tvalid,
    input wire         m_axis_tready,
    input wire [135:0] m_axis_tdata,
    input wire         m_axis_tlast
);

    // A stalled output beat holds.
    `AK_ASSERT(a_out_hold, i_clk, i_rst_n, (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)))

    // tlast goes with round 10 and only with it.
    `AK_ASSERT_IMPL(a_last_round, i_clk, i_rst_n, m_axis_tvalid, m_axis_tlast == (m_axis_tdata[3:0] == 4'd10))

    // A key beat is followed by round 0 carrying the key itself.
    `AK_ASSERT(a_round0, i_clk, i_rst_n, (s_axis_tvalid && s_axis_tready) |=> (m_axis_tvalid && m_axis_tdata[3:0] == 4'd0 && m_axis_tdata[67:4] == $past(s_axis_tdata[63:0]) && m_axis_tdata[131:68] == $past(s_axis_tdata[127:64])))

    // Within a run, the next round follows at once.
    `AK_ASSERT(a_round_step, i_clk, i_rst_n, (m_axis_tvalid && m_axis_tready && !m_axis_tlast) |=> (m_axis_tvalid && m_axis_tdata[3:0] == 4'($past(m_axis_tdata[3:0]) + 4'd1)))

endmodule

bind aes128_key_expansion aes128ke_checker u_aes128ke_checker (.*);
`default_nettype wire

/* verif/aes128_round_key_checker.sv */
`default_nettype none
module aes128_round_key_checker (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 s_axis_tvalid,
    input  wire                                 s_axis_tready,
    // [63:0] key_high, [127:64] key_low
    input  wire  [aes128ke_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    input  wire                                 m_axis_tvalid,
    input  wire                                 m_axis_tready,
    // [3:0] round_index, [67:4] round_key_high, [131:68] round_key_low, [135:132] zero
    input  wire  [aes128ke_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    input  wire                                 m_axis_tlast,
    output int                                  o_fail_count,
    output int                                  o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import aes128ke_pkg::*;

    typedef struct packed {
        t_round      idx;
        logic [63:0] hi;
        logic [63:0] lo;
        logic        last;
    } t_round_key;

    t_round_key round_key_q[$];
    logic [7:0] sub_byte [256];

    function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] p;
        p = 8'h00;
        for (int i = 0; i < 8; i++) begin
            if (b[i]) p ^= a;
            a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
        end
        return p;
    endfunction

    // Derive the S-box: multiplicative inverse in GF(2^8), then the affine map.
    initial begin
        logic [7:0] inv;
        for (int x = 0; x < 256; x++) begin
            inv = 8'h01;
            for (int k = 0; k < 254; k++) inv = gf_mul(inv, 8'(x));
            sub_byte[x] = inv ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]}
                        ^ {inv[4:0], inv[7:5]} ^ {inv[3:0], inv[7:4]} ^ 8'h63;
        end
    end

    // Queue all eleven round keys of one cipher key.
    function automatic void expand_key(input logic [63:0] hi, input logic [63:0] lo);
        logic [31:0] w [4];
        logic [31:0] t;
        logic [7:0]  rc;
        w[0] = hi[63:32];
        w[1] = hi[31:0];
        w[2] = lo[63:32];
        w[3] = lo[31:0];
        rc   = 8'h01;
        round_key_q.push_back('{idx: '0, hi: hi, lo: lo, last: 1'b0});
        for (int r = 1; r <= NUM_ROUNDS; r++) begin
            t = {w[3][23:0], w[3][31:24]};
            t = {sub_byte[t[31:24]] ^ rc, sub_byte[t[23:16]],
                 sub_byte[t[15:8]], sub_byte[t[7:0]]};
            w[0] ^= t;
            w[1] ^= w[0];
            w[2] ^= w[1];
            w[3] ^= w[2];
            round_key_q.push_back('{idx: t_round'(r), hi: {w[0], w[1]},
                                    lo: {w[2], w[3]}, last: (r == NUM_ROUNDS)});
            rc = {rc[6:0], 1'b0} ^ (rc[7] ? 8'h1b : 8'h00);
        end
    endfunction

    always @(posedge i_clk) begin
        t_round_key want;
        t_round_key got;
        if (i_rst_n) begin
            // Check the output beat before queuing this edge's key.
            if (m_axis_tvalid && m_axis_tready) begin
                got = '{idx: m_axis_tdata[3:0], hi: m_axis_tdata[67:4],
                        lo: m_axis_tdata[131:68], last: m_axis_tlast};
                if (round_key_q.size() == 0) begin
                    o_fail_count <= o_fail_count + 1;
                    $display("%0t: unexpected round key beat, actual idx=%0d hi=%h lo=%h last=%b",
                             $time, got.idx, got.hi, got.lo, got.last);
                end else begin
                    want = round_key_q.pop_front();
                    if (got !== want) begin
                        o_fail_count <= o_fail_count + 1;
                        $display("%0t: mismatch, expected idx=%0d hi=%h lo=%h last=%b",
                                 $time, want.idx, want.hi, want.lo, want.last);
                        $display("%0t:           actual   idx=%0d hi=%h lo=%h last=%b",
                                 $time, got.idx, got.hi, got.lo, got.last);
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                expand_key(s_axis_tdata[63:0], s_axis_tdata[127:64]);
            o_pending <= round_key_q.size();
        end
    end

endmodule
`default_nettype wire

/* verif/tb_top.sv */
`default_nettype none
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import aes128ke_pkg::*;

    localparam int RAND_KEYS  = 119;
    localparam int IDLE_PCT   = 35;
    // No beat on either side for this many cycles means the block is stuck.
    localparam int STUCK_LIMIT = 1000;
    // Cycles to watch after the last round key for stray beats.
    localparam int DRAIN_CYCLES = 24;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;   // [63:0] key_high, [127:64] key_low
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;        // [3:0] idx, [67:4] high, [131:68] low
    logic                  m_axis_tlast;

    int fail_count;
    int pending;
    int stuck_cycles = 0;
    // Steady stretch: no idling on either side while set.
    logic steady = 1'b0;

    always #6 i_clk = ~i_clk;

    aes128_key_expansion u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    aes128_round_key_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .o_fail_count  (fail_count),
        .o_pending     (pending)
    );

    // Stall the round key output at random, except in the steady stretch.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= steady || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // Count cycles with no beat on either side; give up when it gets too long.
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            stuck_cycles <= 0;
        end else begin
            stuck_cycles <= stuck_cycles + 1;
            if (stuck_cycles >= STUCK_LIMIT) begin
                $display("%0t: no beat for %0d cycles", $time, STUCK_LIMIT);
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    // Present one key beat and hold it until taken. Leave tvalid high afterwards
    // so a following beat can go out back to back; the caller drops it at the end.
    task automatic send_key(input logic [63:0] key_high, input logic [63:0] key_low);
        while (!steady && $urandom_range(99) < IDLE_PCT) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {key_low, key_high};
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    initial begin
        // Hold reset, then release it at a rising edge.
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed keys: extremes, the standard example key, single bits,
        // alternating patterns and a last word that exercises the rotation.
        send_key(64'h0000_0000_0000_0000, 64'h0000_0000_0000_0000);
        send_key(64'hffff_ffff_ffff_ffff, 64'hffff_ffff_ffff_ffff);
        send_key(64'h2b7e_1516_28ae_d2a6, 64'habf7_1588_09cf_4f3c);
        send_key(64'hffff_ffff_ffff_ffff, 64'h0000_0000_0000_0000);
        send_key(64'h0000_0000_0000_0000, 64'hffff_ffff_ffff_ffff);
        send_key(64'h5555_5555_5555_5555, 64'haaaa_aaaa_aaaa_aaaa);
        send_key(64'haaaa_aaaa_aaaa_aaaa, 64'h5555_5555_5555_5555);
        send_key(64'h0001_0203_0405_0607, 64'h0809_0a0b_0c0d_0e0f);
        send_key(64'h8000_0000_0000_0000, 64'h0000_0000_0000_0001);
        send_key(64'h0000_0000_0000_0000, 64'h0000_0000_ffff_ffff);
        send_key(64'h0000_0000_0000_0000, 64'h1234_5678_0000_0000);

        // Random keys; run a middle stretch with no idling on either side.
        for (int n = 0; n < RAND_KEYS; n++) begin
            steady = (n >= 50 && n < 80);
            send_key({$urandom, $urandom}, {$urandom, $urandom});
        end
        s_axis_tvalid <= 1'b0;
        steady = 1'b0;

        // Let the checker count the last key beat, then drain every outstanding
        // round key and watch a little longer.
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fail_count == 0 && pending == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
`default_nettype wire
